// File: rtl/tat_pkg.sv
// tat_pkg: shared types, command codes, reset values and helpers for the trickle announce timer
// no dependencies; used by trickle_announce_timer

package tat_pkg;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_SUPPRESS  = 3'd1;
    localparam logic [2:0] CMD_PROCESSED = 3'd2;
    localparam logic [2:0] CMD_RESET     = 3'd3;
    localparam logic [2:0] CMD_SET_IVL   = 3'd4;

    localparam logic [1:0] REG_MIN_STAGE   = 2'd0;
    localparam logic [1:0] REG_MAX_STAGE   = 2'd1;
    localparam logic [1:0] REG_TICK_PERIOD = 2'd2;

    localparam logic [3:0]  MIN_STAGE_RST   = 4'd1;
    localparam logic [3:0]  MAX_STAGE_RST   = 4'd15;
    localparam logic [15:0] TICK_PERIOD_RST = 16'd1024;

    localparam logic [15:0] RAND_MOD    = 16'hFFFF;
    localparam logic [15:0] SMALL_COUNT = 16'd4;

    localparam logic [4:0] IVL_STEPS    = 5'd31;
    localparam logic [4:0] JITTER_STEPS = 5'd15;
    localparam logic [5:0] FULL_BITLEN  = 6'd32;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    function automatic logic [15:0] interval_len(input logic [3:0] stg);
        interval_len = 16'd1 << stg;
    endfunction

    // announce point: (rnd mod 65535) mod (len/2), len/2 is a power of two
    function automatic logic [14:0] announce_pick(input logic [3:0] stg,
                                                  input logic [15:0] rnd);
        logic [15:0] len;
        logic [15:0] mask;
        logic [15:0] r;
        len  = 16'd1 << stg;
        mask = (len >> 1) - 16'd1;
        r    = (rnd == RAND_MOD) ? 16'd0 : rnd;
        if (len < SMALL_COUNT)
            announce_pick = 15'd0;
        else
            announce_pick = 15'(r & mask);
    endfunction

endpackage

// File: rtl/trickle_announce_timer.sv
// trickle_announce_timer: trickle timer with command channel, result channel and config port
// depends on tat_pkg (command codes, reset values, announce point helper)
// one restoring divider, one quotient bit per cycle, serves interval and jitter math

// Each command transfer yields one result transfer. A tick with tick_period of two or more
// runs 16 divider steps for the jitter remainder before its result is built; a set interval
// with nonzero tick_period runs 32 divider steps for the quotient, whose bit length is
// tracked as the bits emerge; every other command goes from the transfer straight to the
// result stage. The block takes one command at a time: cmd_ready is high only while the
// divider sequencer is idle, and a finished result waits in the output register until
// result_ready, while the next command may already be taken; that command then finishes
// only once the waiting result is taken. Config writes land at once and are meant for idle
// periods.

module trickle_announce_timer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] interval_req,
    input  logic [15:0] announce_random,
    input  logic [15:0] jitter_random,

    output logic        result_valid,
    input  logic        result_ready,
    output logic        fire,
    output logic [3:0]  stage,
    output logic [15:0] countdown,
    output logic [16:0] next_tick_delay
);

    tat_pkg::state_t state_reg, state_next;

    logic [3:0]  min_stage_reg, max_stage_reg;
    logic [15:0] tick_period_reg;

    logic [2:0]  cmd_reg, cmd_next;
    logic [15:0] arnd_reg, arnd_next;

    logic [31:0] dvd_reg, dvd_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [15:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [5:0]  bitlen_reg, bitlen_next;
    logic        found_reg, found_next;

    logic [3:0]  stage_reg, stage_next;
    logic [15:0] countdown_reg, countdown_next;
    logic [14:0] announce_reg, announce_next;
    logic        suppressed_reg, suppressed_next;
    logic        done_reg, done_next;

    logic        result_valid_reg, result_valid_next;
    logic        fire_reg, fire_next;
    logic [16:0] delay_reg, delay_next;

    logic [16:0] trial;
    logic        ge;
    logic [15:0] cd_dec;
    logic        hit;
    logic        restart;
    logic [3:0]  new_stage;
    logic [5:0]  ivl_stage;
    logic        slot_free;
    logic        cmd_xfer;

    assign cmd_ready       = (state_reg == tat_pkg::S_IDLE);
    assign cmd_xfer        = cmd_valid && cmd_ready;
    assign result_valid    = result_valid_reg;
    assign fire            = fire_reg;
    assign stage           = stage_reg;
    assign countdown       = countdown_reg;
    assign next_tick_delay = delay_reg;

    assign slot_free = !result_valid_reg || result_ready;

    // shared divider step
    assign trial = {rem_reg, dvd_reg[31]};
    assign ge    = (trial >= {1'b0, dsr_reg});

    assign cd_dec = (countdown_reg == 16'd0) ? 16'd0 : countdown_reg - 16'd1;
    assign hit    = (cd_dec <= {1'b0, announce_reg}) && !done_reg;

    always_comb
    begin
        ivl_stage = (bitlen_reg == 6'd0) ? 6'd1 : bitlen_reg;
        if (ivl_stage > {2'b00, max_stage_reg})
        begin
            ivl_stage = {2'b00, max_stage_reg};
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        arnd_next         = arnd_reg;
        dvd_next          = dvd_reg;
        dsr_next          = dsr_reg;
        rem_next          = rem_reg;
        cnt_next          = cnt_reg;
        bitlen_next       = bitlen_reg;
        found_next        = found_reg;
        stage_next        = stage_reg;
        countdown_next    = countdown_reg;
        announce_next     = announce_reg;
        suppressed_next   = suppressed_reg;
        done_next         = done_reg;
        result_valid_next = result_valid_reg && !result_ready;
        fire_next         = fire_reg;
        delay_next        = delay_reg;
        restart           = 1'b0;
        new_stage         = stage_reg;

        case (state_reg)
            tat_pkg::S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    cmd_next    = cmd;
                    arnd_next   = announce_random;
                    rem_next    = 16'd0;
                    found_next  = 1'b0;
                    bitlen_next = 6'd0;
                    state_next  = tat_pkg::S_DONE;
                    if (cmd == tat_pkg::CMD_TICK && tick_period_reg[15:1] != 15'd0)
                    begin
                        dvd_next   = {jitter_random, 16'd0};
                        dsr_next   = {1'b0, tick_period_reg[15:1]};
                        cnt_next   = tat_pkg::JITTER_STEPS;
                        state_next = tat_pkg::S_DIV;
                    end
                    else if (cmd == tat_pkg::CMD_SET_IVL)
                    begin
                        if (tick_period_reg == 16'd0)
                        begin
                            // quotient taken as all ones: its bit length is set to full width
                            bitlen_next = tat_pkg::FULL_BITLEN;
                        end
                        else
                        begin
                            dvd_next   = interval_req;
                            dsr_next   = tick_period_reg;
                            cnt_next   = tat_pkg::IVL_STEPS;
                            state_next = tat_pkg::S_DIV;
                        end
                    end
                end
            end

            tat_pkg::S_DIV:
            begin
                rem_next = ge ? 16'(trial - {1'b0, dsr_reg}) : trial[15:0];
                dvd_next = {dvd_reg[30:0], ge};
                if (ge && !found_reg)
                begin
                    found_next  = 1'b1;
                    bitlen_next = {1'b0, cnt_reg} + 6'd1;
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = tat_pkg::S_DONE;
                end
            end

            tat_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    result_valid_next = 1'b1;
                    fire_next         = 1'b0;
                    delay_next        = 17'd0;
                    state_next        = tat_pkg::S_IDLE;
                    case (cmd_reg)
                        tat_pkg::CMD_TICK:
                        begin
                            delay_next = {1'b0, tick_period_reg} + {1'b0, rem_reg};
                            if (hit)
                            begin
                                countdown_next = cd_dec;
                                done_next      = suppressed_reg;
                                fire_next      = !suppressed_reg;
                            end
                            else if (cd_dec == 16'd0)
                            begin
                                restart   = 1'b1;
                                new_stage = (stage_reg < max_stage_reg) ?
                                            stage_reg + 4'd1 : stage_reg;
                            end
                            else
                            begin
                                countdown_next = cd_dec;
                            end
                        end
                        tat_pkg::CMD_SUPPRESS:
                        begin
                            suppressed_next = 1'b1;
                        end
                        tat_pkg::CMD_PROCESSED:
                        begin
                            done_next = 1'b1;
                        end
                        tat_pkg::CMD_RESET:
                        begin
                            restart   = 1'b1;
                            new_stage = min_stage_reg;
                        end
                        tat_pkg::CMD_SET_IVL:
                        begin
                            restart   = 1'b1;
                            new_stage = ivl_stage[3:0];
                        end
                        default:
                        begin
                            restart = 1'b0;
                        end
                    endcase
                    if (restart)
                    begin
                        stage_next      = new_stage;
                        countdown_next  = tat_pkg::interval_len(new_stage);
                        announce_next   = tat_pkg::announce_pick(new_stage, arnd_reg);
                        suppressed_next = 1'b0;
                        done_next       = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = tat_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tat_pkg::S_IDLE;
            min_stage_reg    <= tat_pkg::MIN_STAGE_RST;
            max_stage_reg    <= tat_pkg::MAX_STAGE_RST;
            tick_period_reg  <= tat_pkg::TICK_PERIOD_RST;
            stage_reg        <= tat_pkg::MIN_STAGE_RST;
            countdown_reg    <= tat_pkg::interval_len(tat_pkg::MIN_STAGE_RST);
            announce_reg     <= 15'd0;
            suppressed_reg   <= 1'b0;
            done_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            found_reg        <= 1'b0;
            cnt_reg          <= 5'd0;
        end
        else
        begin
            state_reg        <= state_next;
            stage_reg        <= stage_next;
            countdown_reg    <= countdown_next;
            announce_reg     <= announce_next;
            suppressed_reg   <= suppressed_next;
            done_reg         <= done_next;
            result_valid_reg <= result_valid_next;
            found_reg        <= found_next;
            cnt_reg          <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tat_pkg::REG_MIN_STAGE:   min_stage_reg   <= cfg_data[3:0];
                    tat_pkg::REG_MAX_STAGE:   max_stage_reg   <= cfg_data[3:0];
                    tat_pkg::REG_TICK_PERIOD: tick_period_reg <= cfg_data;
                    default:                  tick_period_reg <= tick_period_reg;
                endcase
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        arnd_reg   <= arnd_next;
        dvd_reg    <= dvd_next;
        dsr_reg    <= dsr_next;
        rem_reg    <= rem_next;
        bitlen_reg <= bitlen_next;
        fire_reg   <= fire_next;
        delay_reg  <= delay_next;
    end

    // divider never runs with a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tat_pkg::S_DIV |-> dsr_reg != 16'd0)
        else $error("divider running with zero divisor");

    // a command transfer leaves the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("ready after command transfer");

    // a reported fire matches the timer state it was built from
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && fire |-> countdown_reg <= {1'b0, announce_reg} && !done_reg)
        else $error("fire without announce condition");

    // countdown never exceeds the longest interval
    assert property (@(posedge clk) disable iff (!rst_n)
        countdown_reg <= 16'h8000)
        else $error("countdown out of range");

endmodule
